[hw/rtl/spd_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Shared codes and constants for the deframer and its channel interfaces.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Two-byte start code that opens every packet.
  localparam logic [7:0] START_HIGH = 8'hEF;
  localparam logic [7:0] START_LOW  = 8'h01;

  // Type byte values on the link.
  localparam logic [7:0] TYPE_COMMAND = 8'h01;
  localparam logic [7:0] TYPE_DATA    = 8'h02;
  localparam logic [7:0] TYPE_ACK     = 8'h07;
  localparam logic [7:0] TYPE_END     = 8'h08;

  // Packet kind codes reported on results.
  localparam logic [1:0] PK_COMMAND = 2'd0;
  localparam logic [1:0] PK_DATA    = 2'd1;
  localparam logic [1:0] PK_ACK     = 2'd2;
  localparam logic [1:0] PK_END     = 2'd3;

  // Result kind codes.
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
  localparam logic [1:0] ERR_SHORT_LEN = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM  = 2'd3;

  // One result word as held in the output register.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [1:0] packet_kind;
    logic [1:0] error_code;
    logic       last;
  } result_t;

endpackage

[hw/rtl/spd_if.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer channel interfaces
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [1:0] packet_kind;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output packet_kind,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input packet_kind,
                  input error_code, input last, output ready);
endinterface

[hw/rtl/sensor_packet_deframer_unit.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Receive-side deframer: start code hunt, address skip, type and length check,
// payload forwarding and trailing 16-bit checksum verification.
// ----------------------------------------------------------------------------
// Usage: received serial bytes enter on in_ch, one byte per word. Each byte is
// decoded in the cycle it is accepted, and any result it causes is loaded into
// the output register, so it appears on out_ch in the cycle after acceptance.
// Payload bytes come out as kind payload with last low; every packet that gets
// past the start code and address bytes ends with one status word (accepted,
// or rejected with an error code) carrying last high. Payload words have
// already left when the checksum is checked, so a receiver must drop them
// when the status word reports a rejection.
// Throughput is one byte per cycle, set by the single decode stage between
// the input handshake and the output register. A byte is taken while a result
// waits in the output register only if that result is taken in the same cycle;
// when the receiver stalls with a result pending, in_ch.ready drops and the
// pending word holds until taken.
// Reset (synchronous, rst_n low) returns the decoder to hunting for the start
// code and empties the output register.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_unit (
  input  logic             clk,
  input  logic             rst_n,
  spd_in_if.sink           in_ch,
  spd_out_if.source        out_ch
);

  // Decoder phases. Only these nine codes are ever loaded.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_START2  = 4'd1,
    PH_ADDR    = 4'd2,
    PH_TYPE    = 4'd3,
    PH_LENH    = 4'd4,
    PH_LENL    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_SUMH    = 4'd7,
    PH_SUML    = 4'd8
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      kind_held_r, kind_held_nxt;
  logic [15:0]     bytes_left_r, bytes_left_nxt;
  logic [15:0]     running_sum_r, running_sum_nxt;
  logic [7:0]      check_high_r, check_high_nxt;
  logic [1:0]      addr_count_r, addr_count_nxt;

  logic            out_valid_r;
  spd_pkg::result_t out_word_r;

  logic            in_ready;
  logic            in_fire;
  logic            res_valid;
  spd_pkg::result_t res_word;

  logic [7:0]      b;
  logic [15:0]     sum_plus_b;
  logic [15:0]     len;
  logic [15:0]     len_minus_two;
  logic [15:0]     left_minus_one;

  // The input side moves whenever the output register is empty or is being
  // emptied in this cycle.
  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;

  assign b              = in_ch.rx_byte;
  assign sum_plus_b     = running_sum_r + {8'h00, b};
  assign len            = {bytes_left_r[15:8], b};
  assign len_minus_two  = len - 16'd2;
  assign left_minus_one = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt       = phase_r;
    kind_held_nxt   = kind_held_r;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    check_high_nxt  = check_high_r;
    addr_count_nxt  = addr_count_r;
    res_valid       = 1'b0;
    res_word        = '0;

    case (phase_r)
      PH_START2: begin
        if (b == spd_pkg::START_LOW) begin
          addr_count_nxt = 2'd0;
          phase_nxt      = PH_ADDR;
        end else if (b == spd_pkg::START_HIGH) begin
          phase_nxt = PH_START2;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_ADDR: begin
        // Four address bytes are skipped without any check.
        if (addr_count_r == 2'd3) begin
          addr_count_nxt = 2'd0;
          phase_nxt      = PH_TYPE;
        end else begin
          addr_count_nxt = addr_count_r + 2'd1;
        end
      end
      PH_TYPE: begin
        running_sum_nxt = {8'h00, b};
        phase_nxt       = PH_LENH;
        case (b)
          spd_pkg::TYPE_COMMAND: kind_held_nxt = spd_pkg::PK_COMMAND;
          spd_pkg::TYPE_DATA:    kind_held_nxt = spd_pkg::PK_DATA;
          spd_pkg::TYPE_ACK:     kind_held_nxt = spd_pkg::PK_ACK;
          spd_pkg::TYPE_END:     kind_held_nxt = spd_pkg::PK_END;
          default: begin
            // Unknown type: reject at once and leave the other state alone.
            running_sum_nxt      = running_sum_r;
            phase_nxt            = PH_HUNT;
            res_valid            = 1'b1;
            res_word.kind        = spd_pkg::KIND_REJECTED;
            res_word.error_code  = spd_pkg::ERR_BAD_TYPE;
            res_word.last        = 1'b1;
          end
        endcase
      end
      PH_LENH: begin
        bytes_left_nxt  = {b, 8'h00};
        running_sum_nxt = sum_plus_b;
        phase_nxt       = PH_LENL;
      end
      PH_LENL: begin
        running_sum_nxt = sum_plus_b;
        if (len[15:1] == 15'd0) begin
          // A length below two cannot even cover the checksum.
          bytes_left_nxt       = 16'd0;
          phase_nxt            = PH_HUNT;
          res_valid            = 1'b1;
          res_word.kind        = spd_pkg::KIND_REJECTED;
          res_word.packet_kind = kind_held_r;
          res_word.error_code  = spd_pkg::ERR_SHORT_LEN;
          res_word.last        = 1'b1;
        end else begin
          bytes_left_nxt = len_minus_two;
          phase_nxt      = (len_minus_two == 16'd0) ? PH_SUMH : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_nxt       = sum_plus_b;
        bytes_left_nxt        = left_minus_one;
        if (left_minus_one == 16'd0) begin
          phase_nxt = PH_SUMH;
        end
        res_valid             = 1'b1;
        res_word.kind         = spd_pkg::KIND_PAYLOAD;
        res_word.payload_byte = b;
        res_word.packet_kind  = kind_held_r;
      end
      PH_SUMH: begin
        check_high_nxt = b;
        phase_nxt      = PH_SUML;
      end
      PH_SUML: begin
        phase_nxt            = PH_HUNT;
        res_valid            = 1'b1;
        res_word.packet_kind = kind_held_r;
        res_word.last        = 1'b1;
        if ({check_high_r, b} == running_sum_r) begin
          res_word.kind = spd_pkg::KIND_ACCEPTED;
        end else begin
          res_word.kind       = spd_pkg::KIND_REJECTED;
          res_word.error_code = spd_pkg::ERR_CHECKSUM;
        end
      end
      default: begin
        // Hunting: a first start byte moves on, anything else is dropped.
        phase_nxt = (b == spd_pkg::START_HIGH) ? PH_START2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      kind_held_r   <= 2'd0;
      bytes_left_r  <= 16'd0;
      running_sum_r <= 16'd0;
      check_high_r  <= 8'd0;
      addr_count_r  <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r       <= phase_nxt;
        kind_held_r   <= kind_held_nxt;
        bytes_left_r  <= bytes_left_nxt;
        running_sum_r <= running_sum_nxt;
        check_high_r  <= check_high_nxt;
        addr_count_r  <= addr_count_nxt;
      end
      if (in_fire && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result word itself carries no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_word_r.kind;
  assign out_ch.payload_byte = out_word_r.payload_byte;
  assign out_ch.packet_kind  = out_word_r.packet_kind;
  assign out_ch.error_code   = out_word_r.error_code;
  assign out_ch.last         = out_word_r.last;

  // The input side only stalls behind a pending result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("input stalled with an empty output register");

  // Every accepted payload byte produces a result word.
  a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_PAYLOAD) |=> out_valid_r)
    else $error("payload byte accepted without a result");

  // The checksum low byte always closes the packet.
  a_suml_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_SUML) |=> (phase_r == PH_HUNT && out_valid_r && out_ch.last))
    else $error("checksum byte did not close the packet");

  // Payload words never carry status information.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.kind == spd_pkg::KIND_PAYLOAD) |->
      (!out_word_r.last && out_word_r.error_code == spd_pkg::ERR_NONE))
    else $error("payload word carries status bits");

  // The address counter is idle outside the address phase.
  a_addr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_ADDR) |-> (addr_count_r == 2'd0))
    else $error("address counter running outside the address phase");

endmodule
